@@ rtl/core/qau_pkg.sv @@
// Shared types, constants and term tables for the quaternion arithmetic unit.
// Used by every file of the block; depends on nothing.
package qau_pkg;

   localparam int FRAC_BITS   = 14;
   localparam int DATA_WIDTH  = 18;
   localparam int QUEUE_DEPTH = 4;

   // command code that produces no result
   localparam logic [1:0] CMD_NONE = 2'd3;

   typedef enum logic [1:0] {
      OP_MUL = 2'd0,
      OP_ROT = 2'd1,
      OP_MAT = 2'd2
   } op_type;

   // head of the command queue as seen by the execute side
   typedef struct packed {
      logic   valid;
      op_type op;
   } head_type;

   // Hamilton product a*b: for result j, term k uses a[k] and b[HAM_B[j][k]]
   localparam logic [1:0] HAM_B [4][4] = '{
      '{2'd0, 2'd1, 2'd2, 2'd3},
      '{2'd1, 2'd0, 2'd3, 2'd2},
      '{2'd2, 2'd3, 2'd0, 2'd1},
      '{2'd3, 2'd2, 2'd1, 2'd0}
   };
   localparam logic HAM_NEG [4][4] = '{
      '{1'b0, 1'b1, 1'b1, 1'b1},
      '{1'b0, 1'b0, 1'b0, 1'b1},
      '{1'b0, 1'b1, 1'b0, 1'b0},
      '{1'b0, 1'b0, 1'b1, 1'b0}
   };

   // one matrix entry: +-2*q[a0]*q[b0] +-2*q[a1]*q[b1] (+1.0)
   typedef struct packed {
      logic [1:0] a0;
      logic [1:0] b0;
      logic       n0;
      logic [1:0] a1;
      logic [1:0] b1;
      logic       n1;
      logic       one;
   } mterm_type;

   // index: w 0, x 1, y 2, z 3
   function automatic mterm_type mat_term(input logic [1:0] row, input logic [1:0] col);
      mterm_type t;
      t = '0;
      unique case ({row, col})
         4'h0: t = '{2'd2, 2'd2, 1'b1, 2'd3, 2'd3, 1'b1, 1'b1};
         4'h1: t = '{2'd1, 2'd2, 1'b0, 2'd0, 2'd3, 1'b1, 1'b0};
         4'h2: t = '{2'd1, 2'd3, 1'b0, 2'd0, 2'd2, 1'b0, 1'b0};
         4'h4: t = '{2'd1, 2'd2, 1'b0, 2'd0, 2'd3, 1'b0, 1'b0};
         4'h5: t = '{2'd1, 2'd1, 1'b1, 2'd3, 2'd3, 1'b1, 1'b1};
         4'h6: t = '{2'd2, 2'd3, 1'b0, 2'd0, 2'd1, 1'b1, 1'b0};
         4'h8: t = '{2'd1, 2'd3, 1'b0, 2'd0, 2'd2, 1'b1, 1'b0};
         4'h9: t = '{2'd2, 2'd3, 1'b0, 2'd0, 2'd1, 1'b0, 1'b0};
         4'hA: t = '{2'd1, 2'd1, 1'b1, 2'd2, 2'd2, 1'b1, 1'b1};
         default: t = '0;
      endcase
      return t;
   endfunction

endpackage

@@ rtl/core/qau_chan_if.sv @@
// Valid/ready channel interfaces for the command and result streams.
// Depends on qau_pkg for the default field width.
interface qau_req_if #(parameter int DATA_WIDTH = qau_pkg::DATA_WIDTH);
   logic                         valid;
   logic                         ready;
   logic [1:0]                   cmd;
   logic signed [DATA_WIDTH-1:0] q_w;
   logic signed [DATA_WIDTH-1:0] q_x;
   logic signed [DATA_WIDTH-1:0] q_y;
   logic signed [DATA_WIDTH-1:0] q_z;
   logic signed [DATA_WIDTH-1:0] r_w;
   logic signed [DATA_WIDTH-1:0] r_x;
   logic signed [DATA_WIDTH-1:0] r_y;
   logic signed [DATA_WIDTH-1:0] r_z;
   modport source (output valid, cmd, q_w, q_x, q_y, q_z, r_w, r_x, r_y, r_z, input ready);
   modport sink   (input valid, cmd, q_w, q_x, q_y, q_z, r_w, r_x, r_y, r_z, output ready);
endinterface

interface qau_rsp_if #(parameter int DATA_WIDTH = qau_pkg::DATA_WIDTH);
   logic                         valid;
   logic                         ready;
   logic signed [DATA_WIDTH-1:0] out_w;
   logic signed [DATA_WIDTH-1:0] out_x;
   logic signed [DATA_WIDTH-1:0] out_y;
   logic signed [DATA_WIDTH-1:0] out_z;
   logic                         last;
   modport source (output valid, out_w, out_x, out_y, out_z, last, input ready);
   modport sink   (input valid, out_w, out_x, out_y, out_z, last, output ready);
endinterface

@@ rtl/core/qau_front.sv @@
// Front end: accepts command transactions, drops unused commands and queues the rest.
// Depends on qau_pkg and qau_chan_if.
module qau_front #(
   parameter int DATA_WIDTH  = qau_pkg::DATA_WIDTH,
   parameter int QUEUE_DEPTH = qau_pkg::QUEUE_DEPTH
) (
   input  logic                         clock,
   input  logic                         reset,
   qau_req_if.sink                      req_if,
   output qau_pkg::head_type            head,
   output logic signed [DATA_WIDTH-1:0] head_q [4],
   output logic signed [DATA_WIDTH-1:0] head_r [4],
   input  logic                         pop
);
   localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   qau_pkg::op_type              op_ff [QUEUE_DEPTH];
   logic signed [DATA_WIDTH-1:0] q_ff  [QUEUE_DEPTH][4];
   logic signed [DATA_WIDTH-1:0] r_ff  [QUEUE_DEPTH][4];
   logic [PW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          push;

   assign req_if.ready = (cnt_ff != CW'(QUEUE_DEPTH));
   assign push = req_if.valid && req_if.ready && (req_if.cmd != qau_pkg::CMD_NONE);

   // advance pointers and occupancy
   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = (wr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (pop) begin
         rd_in = (rd_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // store the classified transaction
   always_ff @(posedge clock) begin
      if (push) begin
         op_ff[wr_ff]    <= qau_pkg::op_type'(req_if.cmd);
         q_ff[wr_ff][0]  <= req_if.q_w;
         q_ff[wr_ff][1]  <= req_if.q_x;
         q_ff[wr_ff][2]  <= req_if.q_y;
         q_ff[wr_ff][3]  <= req_if.q_z;
         r_ff[wr_ff][0]  <= req_if.r_w;
         r_ff[wr_ff][1]  <= req_if.r_x;
         r_ff[wr_ff][2]  <= req_if.r_y;
         r_ff[wr_ff][3]  <= req_if.r_z;
      end
   end

   assign head.valid = (cnt_ff != '0);
   assign head.op    = op_ff[rd_ff];
   assign head_q     = q_ff[rd_ff];
   assign head_r     = r_ff[rd_ff];

endmodule

@@ rtl/core/qau_back.sv @@
// Execute side: expands matrix commands into rows and runs the four-stage product pipeline.
// Depends on qau_pkg and qau_chan_if.
module qau_back #(
   parameter int DATA_WIDTH = qau_pkg::DATA_WIDTH,
   parameter int FRAC_BITS  = qau_pkg::FRAC_BITS
) (
   input  logic                         clock,
   input  logic                         reset,
   input  qau_pkg::head_type            head,
   input  logic signed [DATA_WIDTH-1:0] head_q [4],
   input  logic signed [DATA_WIDTH-1:0] head_r [4],
   output logic                         pop,
   qau_rsp_if.source                    rsp_if
);
   localparam int DW  = DATA_WIDTH;
   localparam int PW  = 2 * DW;
   localparam int BW  = (PW > 2 * FRAC_BITS + 1) ? PW : 2 * FRAC_BITS + 1;
   localparam int AW  = BW + 4;
   localparam logic signed [AW-1:0] ONE_V  = {{(AW-1){1'b0}}, 1'b1} << (2 * FRAC_BITS);
   localparam logic signed [AW-1:0] HALF_V = {{(AW-1){1'b0}}, 1'b1} << (FRAC_BITS - 1);
   localparam logic signed [AW-1:0] MAX_V  = {{(AW-DW+1){1'b0}}, {(DW-1){1'b1}}};
   localparam logic signed [AW-1:0] MIN_V  = ~MAX_V;

   // sum the signed terms, round half up and saturate
   function automatic logic signed [DW-1:0] fold(input logic signed [PW-1:0] p [4],
                                                  input logic [3:0] ng, input logic dbl,
                                                  input logic one);
      logic signed [AW-1:0] acc;
      logic signed [AW-1:0] term;
      logic signed [AW-1:0] v;
      acc = one ? ONE_V : '0;
      for (int k = 0; k < 4; k++) begin
         term = AW'(p[k]);
         if (dbl) begin
            term = term <<< 1;
         end
         acc = ng[k] ? acc - term : acc + term;
      end
      v = (acc + HALF_V) >>> FRAC_BITS;
      if (v > MAX_V) begin
         return MAX_V[DW-1:0];
      end else if (v < MIN_V) begin
         return MIN_V[DW-1:0];
      end
      return v[DW-1:0];
   endfunction

   logic [1:0] row_ff, row_in;
   logic       v1_ff, v2_ff, v3_ff, v4_ff;
   logic       adv1, adv2, adv3, adv4;
   logic       issue, row_last;

   logic signed [DW-1:0] a_sel [4][4];
   logic signed [DW-1:0] b_sel [4][4];
   logic [3:0]           n_sel [4];
   logic [3:0]           one_sel;

   qau_pkg::op_type      op1_ff, op2_ff, op3_ff;
   logic                 last1_ff, last2_ff, last3_ff;
   logic                 dbl1_ff;
   logic [3:0]           one1_ff;
   logic [3:0]           n1_ff [4];
   logic signed [PW-1:0] p1_ff [4][4];
   logic signed [DW-1:0] q1_ff [4], q2_ff [4];
   logic signed [DW-1:0] o2_ff [4], o2_in [4];
   logic signed [DW-1:0] o3_ff [4];
   logic signed [PW-1:0] p3_ff [4][4];
   logic signed [DW-1:0] o4_in [4];
   logic signed [DW-1:0] o4_ff [4];
   logic                 last4_ff;

   // stall chain: a stage loads when it is empty or its contents move on
   assign adv4 = !v4_ff || rsp_if.ready;
   assign adv3 = !v3_ff || adv4;
   assign adv2 = !v2_ff || adv3;
   assign adv1 = !v1_ff || adv2;

   assign issue    = head.valid && adv1;
   assign row_last = (head.op != qau_pkg::OP_MAT) || (row_ff == 2'd2);
   assign pop      = issue && row_last;

   // step through matrix rows
   always_comb begin
      row_in = row_ff;
      if (issue) begin
         row_in = row_last ? 2'd0 : row_ff + 2'd1;
      end
   end

   // select first-pass operands
   always_comb begin
      qau_pkg::mterm_type mt;
      one_sel = '0;
      mt      = '0;
      for (int j = 0; j < 4; j++) begin
         for (int k = 0; k < 4; k++) begin
            a_sel[j][k] = head_q[k];
            b_sel[j][k] = head_r[qau_pkg::HAM_B[j][k]];
            n_sel[j][k] = qau_pkg::HAM_NEG[j][k];
            if (head.op == qau_pkg::OP_ROT && qau_pkg::HAM_B[j][k] == 2'd0) begin
               b_sel[j][k] = '0;
            end
            if (head.op == qau_pkg::OP_MAT) begin
               a_sel[j][k] = '0;
               b_sel[j][k] = '0;
               n_sel[j][k] = 1'b0;
            end
         end
         if (head.op == qau_pkg::OP_MAT && j != 0) begin
            mt          = qau_pkg::mat_term(row_ff, 2'(j - 1));
            a_sel[j][0] = head_q[mt.a0];
            b_sel[j][0] = head_q[mt.b0];
            n_sel[j][0] = mt.n0;
            a_sel[j][1] = head_q[mt.a1];
            b_sel[j][1] = head_q[mt.b1];
            n_sel[j][1] = mt.n1;
            one_sel[j]  = mt.one;
         end
      end
   end

   // first-pass sums
   always_comb begin
      for (int j = 0; j < 4; j++) begin
         o2_in[j] = fold(p1_ff[j], n1_ff[j], dbl1_ff, one1_ff[j]);
      end
   end

   // second-pass sums for rotate; pass other results through
   always_comb begin
      for (int j = 0; j < 4; j++) begin
         o4_in[j] = o3_ff[j];
      end
      if (op3_ff == qau_pkg::OP_ROT) begin
         o4_in[0] = '0;
         for (int j = 1; j < 4; j++) begin
            o4_in[j] = fold(p3_ff[j], {qau_pkg::HAM_NEG[j][3] ^ (qau_pkg::HAM_B[j][3] != 2'd0),
                                       qau_pkg::HAM_NEG[j][2] ^ (qau_pkg::HAM_B[j][2] != 2'd0),
                                       qau_pkg::HAM_NEG[j][1] ^ (qau_pkg::HAM_B[j][1] != 2'd0),
                                       qau_pkg::HAM_NEG[j][0] ^ (qau_pkg::HAM_B[j][0] != 2'd0)},
                            1'b0, 1'b0);
         end
      end
   end

   // hold stage occupancy
   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
         v1_ff  <= 1'b0;
         v2_ff  <= 1'b0;
         v3_ff  <= 1'b0;
         v4_ff  <= 1'b0;
      end else begin
         row_ff <= row_in;
         if (adv1) v1_ff <= issue;
         if (adv2) v2_ff <= v1_ff;
         if (adv3) v3_ff <= v2_ff;
         if (adv4) v4_ff <= v3_ff;
      end
   end

   // stage 1: first-pass products
   always_ff @(posedge clock) begin
      if (adv1) begin
         op1_ff   <= head.op;
         last1_ff <= row_last;
         dbl1_ff  <= (head.op == qau_pkg::OP_MAT);
         one1_ff  <= one_sel;
         q1_ff    <= head_q;
         for (int j = 0; j < 4; j++) begin
            n1_ff[j] <= n_sel[j];
            for (int k = 0; k < 4; k++) begin
               p1_ff[j][k] <= a_sel[j][k] * b_sel[j][k];
            end
         end
      end
   end

   // stage 2: first-pass rounded result
   always_ff @(posedge clock) begin
      if (adv2) begin
         op2_ff   <= op1_ff;
         last2_ff <= last1_ff;
         q2_ff    <= q1_ff;
         o2_ff    <= o2_in;
      end
   end

   // stage 3: products of t and q for the rotate back-half
   always_ff @(posedge clock) begin
      if (adv3) begin
         op3_ff   <= op2_ff;
         last3_ff <= last2_ff;
         o3_ff    <= o2_ff;
         for (int j = 0; j < 4; j++) begin
            for (int k = 0; k < 4; k++) begin
               p3_ff[j][k] <= o2_ff[k] * q2_ff[qau_pkg::HAM_B[j][k]];
            end
         end
      end
   end

   // stage 4: output register
   always_ff @(posedge clock) begin
      if (adv4) begin
         o4_ff    <= o4_in;
         last4_ff <= last3_ff;
      end
   end

   assign rsp_if.valid = v4_ff;
   assign rsp_if.out_w = o4_ff[0];
   assign rsp_if.out_x = o4_ff[1];
   assign rsp_if.out_y = o4_ff[2];
   assign rsp_if.out_z = o4_ff[3];
   assign rsp_if.last  = last4_ff;

endmodule

@@ rtl/core/quaternion_arith_unit.sv @@
// Quaternion arithmetic unit, Q(DATA_WIDTH-FRAC_BITS-1).FRAC_BITS signed fixed point.
// Top level; depends on qau_pkg, qau_chan_if, qau_front and qau_back.
//
// Usage:
//   req_if carries one command transaction: cmd, q_w..q_z, r_w..r_z.
//   cmd 0 returns the Hamilton product q*r, cmd 1 the vector r_x..r_z
//   rotated by q (out_w zero), cmd 2 the rotation matrix of q as three
//   row transactions with last set on the third. cmd 3 is dropped.
//   rsp_if carries out_w..out_z and last; every value is rounded half up
//   and saturated.
// Throughput: one transaction per cycle for cmd 0 and 1 while rsp_if.ready allows; cmd 2
//   takes the issue slot of the product pipeline once per row.
// A 4-entry command queue separates the accept side from the four-stage
//   multiply/sum pipeline; req_if.ready drops only while that queue is full.
// Reset empties the queue and the pipeline. When rsp_if.ready is low the
//   pipeline stages fill and hold, then the queue fills, then req_if.ready
//   falls; no transaction is lost.
module quaternion_arith_unit #(
   parameter int DATA_WIDTH  = qau_pkg::DATA_WIDTH,
   parameter int FRAC_BITS   = qau_pkg::FRAC_BITS,
   parameter int QUEUE_DEPTH = qau_pkg::QUEUE_DEPTH
) (
   input logic       clock,
   input logic       reset,
   qau_req_if.sink   req_if,
   qau_rsp_if.source rsp_if
);
   qau_pkg::head_type            head;
   logic signed [DATA_WIDTH-1:0] head_q [4];
   logic signed [DATA_WIDTH-1:0] head_r [4];
   logic                         pop;

   qau_front #(
      .DATA_WIDTH (DATA_WIDTH),
      .QUEUE_DEPTH(QUEUE_DEPTH)
   ) u_front (
      .clock (clock),
      .reset (reset),
      .req_if(req_if),
      .head  (head),
      .head_q(head_q),
      .head_r(head_r),
      .pop   (pop)
   );

   qau_back #(
      .DATA_WIDTH(DATA_WIDTH),
      .FRAC_BITS (FRAC_BITS)
   ) u_back (
      .clock (clock),
      .reset (reset),
      .head  (head),
      .head_q(head_q),
      .head_r(head_r),
      .pop   (pop),
      .rsp_if(rsp_if)
   );

endmodule

@@ rtl/core/qau_checker.sv @@
// Port-level checks on the result stream of the quaternion unit, bound to the top level.
// Depends on qau_pkg and quaternion_arith_unit.
module qau_checker #(
   parameter int DATA_WIDTH = qau_pkg::DATA_WIDTH
) (
   input logic                         clock,
   input logic                         reset,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic signed [DATA_WIDTH-1:0] rsp_w,
   input logic                         rsp_last
);
   // nothing leaves right after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_w) && $stable(rsp_last))
      else $error("stalled result changed");

   // only matrix rows end without last, and they have no scalar part
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> rsp_w == '0)
      else $error("non-final row with nonzero w");

   // matrix rows follow each other without a gap
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last |=> rsp_valid)
      else $error("gap between matrix rows");

endmodule

bind quaternion_arith_unit qau_checker #(.DATA_WIDTH(DATA_WIDTH)) u_qau_checker (
   .clock    (clock),
   .reset    (reset),
   .rsp_valid(rsp_if.valid),
   .rsp_ready(rsp_if.ready),
   .rsp_w    (rsp_if.out_w),
   .rsp_last (rsp_if.last)
);

@@ test/quaternion_arith_unit_checker.sv @@
// Checker for the quaternion arithmetic unit: watches both channels, predicts
// every result transaction and compares it. Depends on qau_pkg and qau_chan_if.
module quaternion_arith_unit_checker (
   input  logic    clock,
   input  logic    reset,
   qau_req_if.sink req_mon,
   qau_rsp_if.sink rsp_mon,
   output int      fail_count,
   output int      pending_count
);
   localparam int W = qau_pkg::DATA_WIDTH;

   typedef logic signed [W-1:0] fix_type;

   typedef struct packed {
      fix_type w;
      fix_type x;
      fix_type y;
      fix_type z;
      logic    last;
   } qres_type;

   qres_type expected_results[$];

   // floor division by 2^FRAC_BITS
   function automatic longint floor_frac(input longint v);
      return v >>> qau_pkg::FRAC_BITS;
   endfunction

   // round an exact Q(2F) sum half up, then saturate to W bits
   function automatic longint round_sat(input longint whole, input longint frac);
      longint v, hi, lo;
      hi = (longint'(1) <<< (W - 1)) - 1;
      lo = -(longint'(1) <<< (W - 1));
      v = whole + floor_frac(frac + (longint'(1) <<< (qau_pkg::FRAC_BITS - 1)));
      if (v > hi) return hi;
      if (v < lo) return lo;
      return v;
   endfunction

   // sum of up to four products times coefficients plus an optional 1.0
   function automatic longint dot4(input longint a[4], input longint b[4],
                                   input longint c[4], input longint one);
      longint whole, frac, p, h;
      whole = one <<< qau_pkg::FRAC_BITS;
      frac = 0;
      for (int k = 0; k < 4; k++) begin
         p = a[k] * b[k];
         h = floor_frac(p);
         whole += c[k] * h;
         frac += c[k] * (p - (h <<< qau_pkg::FRAC_BITS));
      end
      return round_sat(whole, frac);
   endfunction

   function automatic void hamilton(input longint a[4], input longint b[4],
                                    output longint o[4]);
      o[0] = dot4(a, '{b[0], b[1], b[2], b[3]}, '{1, -1, -1, -1}, 0);
      o[1] = dot4(a, '{b[1], b[0], b[3], b[2]}, '{1, 1, 1, -1}, 0);
      o[2] = dot4(a, '{b[2], b[3], b[0], b[1]}, '{1, -1, 1, 1}, 0);
      o[3] = dot4(a, '{b[3], b[2], b[1], b[0]}, '{1, 1, -1, 1}, 0);
   endfunction

   function automatic longint pair2(input longint a0, input longint b0, input longint c0,
                                    input longint a1, input longint b1, input longint c1,
                                    input longint one);
      return dot4('{a0, a1, 0, 0}, '{b0, b1, 0, 0}, '{c0, c1, 0, 0}, one);
   endfunction

   // queue the results that one command transaction causes
   task automatic predict_command(input logic [1:0] cmd, input longint q[4],
                                  input longint r[4]);
      longint o[4], t[4], v[4], c[4];
      longint w, x, y, z;
      w = q[0]; x = q[1]; y = q[2]; z = q[3];
      unique case (cmd)
         qau_pkg::OP_MUL: begin
            hamilton(q, r, o);
            expected_results.push_back({fix_type'(o[0]), fix_type'(o[1]), fix_type'(o[2]),
                                        fix_type'(o[3]), 1'b1});
         end
         qau_pkg::OP_ROT: begin
            v = '{0, r[1], r[2], r[3]};
            hamilton(q, v, t);
            c = '{q[0], -q[1], -q[2], -q[3]};
            hamilton(t, c, o);
            expected_results.push_back({fix_type'(0), fix_type'(o[1]), fix_type'(o[2]),
                                        fix_type'(o[3]), 1'b1});
         end
         qau_pkg::OP_MAT: begin
            expected_results.push_back({fix_type'(0),
               fix_type'(pair2(y, y, -2, z, z, -2, 1)),
               fix_type'(pair2(x, y, 2, w, z, -2, 0)),
               fix_type'(pair2(x, z, 2, w, y, 2, 0)), 1'b0});
            expected_results.push_back({fix_type'(0),
               fix_type'(pair2(x, y, 2, w, z, 2, 0)),
               fix_type'(pair2(x, x, -2, z, z, -2, 1)),
               fix_type'(pair2(y, z, 2, w, x, -2, 0)), 1'b0});
            expected_results.push_back({fix_type'(0),
               fix_type'(pair2(x, z, 2, w, y, -2, 0)),
               fix_type'(pair2(y, z, 2, w, x, 2, 0)),
               fix_type'(pair2(x, x, -2, y, y, -2, 1)), 1'b1});
         end
         default: ;
      endcase
   endtask

   task automatic compare_field(input string name, input logic [W-1:0] exp_v,
                                input logic [W-1:0] act_v);
      if (exp_v !== act_v) begin
         $error("%s mismatch: expected %0d, actual %0d", name,
                $signed(exp_v), $signed(act_v));
         fail_count++;
      end
   endtask

   assign pending_count = expected_results.size();

   // predict on accepted commands, compare accepted results
   always @(posedge clock) begin
      qres_type e;
      longint q[4], r[4];
      if (reset) begin
         expected_results.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_results.size() == 0) begin
               $error("result transaction with no expectation waiting");
               fail_count++;
            end else begin
               e = expected_results.pop_front();
               compare_field("out_w", e.w, rsp_mon.out_w);
               compare_field("out_x", e.x, rsp_mon.out_x);
               compare_field("out_y", e.y, rsp_mon.out_y);
               compare_field("out_z", e.z, rsp_mon.out_z);
               if (e.last !== rsp_mon.last) begin
                  $error("last mismatch: expected %0d, actual %0d", e.last, rsp_mon.last);
                  fail_count++;
               end
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            q = '{req_mon.q_w, req_mon.q_x, req_mon.q_y, req_mon.q_z};
            r = '{req_mon.r_w, req_mon.r_x, req_mon.r_y, req_mon.r_z};
            predict_command(req_mon.cmd, q, r);
         end
      end
   end

   initial fail_count = 0;
endmodule

@@ test/quaternion_arith_unit_tb.sv @@
// Testbench top for the quaternion arithmetic unit: drives command traffic
// with random idling and gives the verdict. Depends on qau_pkg, qau_chan_if,
// quaternion_arith_unit and quaternion_arith_unit_checker.
module quaternion_arith_unit_tb;
   localparam int W = qau_pkg::DATA_WIDTH;
   localparam int F = qau_pkg::FRAC_BITS;
   localparam int CYCLE_LIMIT = 200000;

   logic clock;
   logic reset;
   int   fail_count;
   int   pending_count;
   int   cycle_count;
   int   send_idle_pct;
   int   recv_idle_pct;

   qau_req_if req_if ();
   qau_rsp_if rsp_if ();

   quaternion_arith_unit DUT (
      .clock (clock),
      .reset (reset),
      .req_if(req_if.sink),
      .rsp_if(rsp_if.source)
   );

   quaternion_arith_unit_checker checker_inst (
      .clock        (clock),
      .reset        (reset),
      .req_mon      (req_if.sink),
      .rsp_mon      (rsp_if.sink),
      .fail_count   (fail_count),
      .pending_count(pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // stop a hung run
   initial cycle_count = 0;
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("quaternion_arith_unit_tb failed");
         $finish;
      end
   end

   // receiver stalls at random
   always @(posedge clock) begin
      if (reset) rsp_if.ready <= 1'b0;
      else rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   function automatic logic [W-1:0] pick_value();
      unique case ($urandom_range(7))
         0: return {1'b1, {(W-1){1'b0}}};
         1: return {1'b0, {(W-1){1'b1}}};
         2: return W'(1 << F);
         3: return -W'(1 << F);
         4, 5: return W'($urandom_range(2 << F)) - W'(1 << F);
         default: return W'($urandom);
      endcase
   endfunction

   // hold one command until accepted, idling first at random
   task automatic send_command(input logic [1:0] cmd, input logic [W-1:0] v[8]);
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.cmd <= cmd;
      req_if.q_w <= v[0]; req_if.q_x <= v[1]; req_if.q_y <= v[2]; req_if.q_z <= v[3];
      req_if.r_w <= v[4]; req_if.r_x <= v[5]; req_if.r_y <= v[6]; req_if.r_z <= v[7];
      do @(posedge clock); while (!req_if.ready);
   endtask

   task automatic send_random(input int count);
      logic [W-1:0] v[8];
      logic [1:0]   cmd;
      for (int n = 0; n < count; n++) begin
         foreach (v[k]) v[k] = pick_value();
         cmd = ($urandom_range(15) == 0) ? qau_pkg::CMD_NONE : 2'($urandom_range(2));
         send_command(cmd, v);
      end
   endtask

   initial begin
      logic [W-1:0] v[8];
      logic [W-1:0] mn, mx, one;
      mn = {1'b1, {(W-1){1'b0}}};
      mx = {1'b0, {(W-1){1'b1}}};
      one = W'(1 << F);
      reset = 1'b1;
      send_idle_pct = 16;
      recv_idle_pct = 58;
      req_if.valid = 1'b0;
      req_if.cmd = qau_pkg::OP_MUL;
      {req_if.q_w, req_if.q_x, req_if.q_y, req_if.q_z} = '0;
      {req_if.r_w, req_if.r_x, req_if.r_y, req_if.r_z} = '0;
      rsp_if.ready = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed: extremes, every command, unused command
      v = '{one, 0, 0, 0, one, 0, 0, 0};
      send_command(qau_pkg::OP_MUL, v);
      send_command(qau_pkg::OP_ROT, v);
      send_command(qau_pkg::OP_MAT, v);
      v = '{mn, mn, mn, mn, mn, mn, mn, mn};
      send_command(qau_pkg::OP_MUL, v);
      send_command(qau_pkg::OP_ROT, v);
      send_command(qau_pkg::OP_MAT, v);
      v = '{mx, mx, mx, mx, mx, mx, mx, mx};
      send_command(qau_pkg::OP_MUL, v);
      send_command(qau_pkg::OP_ROT, v);
      send_command(qau_pkg::OP_MAT, v);
      v = '{mx, mn, mx, mn, mn, mx, mn, mx};
      send_command(qau_pkg::OP_MUL, v);
      send_command(qau_pkg::OP_ROT, v);
      send_command(qau_pkg::OP_MAT, v);
      v = '{0, mn, 0, 0, 0, one, one, one};
      send_command(qau_pkg::OP_ROT, v);
      send_command(qau_pkg::CMD_NONE, v);
      v = '{W'(1), W'(-1), W'(8191), W'(8192), W'(-8192), W'(3), W'(-3), W'(1)};
      send_command(qau_pkg::OP_MUL, v);
      send_command(qau_pkg::OP_MAT, v);

      send_random(27);
      send_idle_pct = 58;
      recv_idle_pct = 16;
      send_random(27);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      send_random(27);
      req_if.valid <= 1'b0;

      // drain, then let the pipeline settle
      while (pending_count != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (fail_count == 0) $display("quaternion_arith_unit_tb passed");
      else $display("quaternion_arith_unit_tb failed");
      $finish;
   end
endmodule

@@ quaternion_arith_unit.f @@
rtl/core/qau_pkg.sv
rtl/core/qau_chan_if.sv
rtl/core/qau_front.sv
rtl/core/qau_back.sv
rtl/core/quaternion_arith_unit.sv
rtl/core/qau_checker.sv
test/quaternion_arith_unit_checker.sv
test/quaternion_arith_unit_tb.sv
